FILE: src/rshe_pkg.sv
package rshe_pkg;

    // iterations of the square root and divider units done per pipeline stage
    localparam int STEPS_PER_STAGE = 2;

    localparam int OUT_W = 18;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CFG_DEGREE = 1'b0,
        CFG_ORDER  = 1'b1
    } t_cfg_idx;

endpackage

FILE: src/rshe_isqrt.sv
module rshe_isqrt #(
    parameter int SW = 62,
    localparam int RW = SW / 2,
    localparam int NSTG = (RW + rshe_pkg::STEPS_PER_STAGE - 1) / rshe_pkg::STEPS_PER_STAGE
) (
    input  logic            i_clk,
    input  logic [NSTG-1:0] i_ld,
    input  logic [SW-1:0]   i_rad,
    output logic [RW-1:0]   o_root
);
    import rshe_pkg::*;

    localparam int REMW = RW + 2;

    logic [SW-1:0]   r_rad  [NSTG];
    logic [REMW-1:0] r_rem  [NSTG];
    logic [RW-1:0]   r_root [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        logic [SW-1:0]   p_rad;
        logic [REMW-1:0] p_rem;
        logic [RW-1:0]   p_root;
        logic [SW-1:0]   n_rad;
        logic [REMW-1:0] n_rem;
        logic [RW-1:0]   n_root;

        if (k == 0) begin : g_first
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
        end else begin : g_next
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
        end

        // one result bit per step: bring down two radicand bits, try 4*root+1
        always_comb begin
            logic [REMW+1:0] rem2;
            logic [REMW+1:0] trial;
            n_rad  = p_rad;
            n_rem  = p_rem;
            n_root = p_root;
            rem2   = '0;
            trial  = '0;
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                if (k * STEPS_PER_STAGE + j < RW) begin
                    rem2  = {n_rem, n_rad[SW-1 -: 2]};
                    trial = {2'b00, n_root, 2'b01};
                    n_rad = n_rad << 2;
                    if (rem2 >= trial) begin
                        rem2   = rem2 - trial;
                        n_root = {n_root[RW-2:0], 1'b1};
                    end else begin
                        n_root = {n_root[RW-2:0], 1'b0};
                    end
                    n_rem = rem2[REMW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ld[k]) begin
                r_rad[k]  <= n_rad;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_root = r_root[NSTG-1];

endmodule

FILE: src/rshe_div.sv
module rshe_div #(
    parameter int RW = 31,
    parameter int QN = 18,
    localparam int NSTG = (QN + rshe_pkg::STEPS_PER_STAGE - 1) / rshe_pkg::STEPS_PER_STAGE
) (
    input  logic            i_clk,
    input  logic [NSTG-1:0] i_ld,
    input  logic [RW-1:0]   i_s,
    input  logic [RW-1:0]   i_a [3],
    output logic [QN-1:0]   o_q [3]
);
    import rshe_pkg::*;

    // three lanes share the divisor; the dividend never exceeds the divisor
    logic [RW-1:0] r_s [NSTG];
    logic [RW:0]   r_r [NSTG][3];
    logic [QN-1:0] r_q [NSTG][3];

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        logic [RW-1:0] p_s;
        logic [RW:0]   p_r [3];
        logic [QN-1:0] p_q [3];
        logic [RW:0]   n_r [3];
        logic [QN-1:0] n_q [3];

        if (k == 0) begin : g_first
            assign p_s = i_s;
            for (genvar i = 0; i < 3; i++) begin : g_ln
                assign p_r[i] = {1'b0, i_a[i]};
                assign p_q[i] = '0;
            end
        end else begin : g_next
            assign p_s = r_s[k-1];
            for (genvar i = 0; i < 3; i++) begin : g_ln
                assign p_r[i] = r_r[k-1][i];
                assign p_q[i] = r_q[k-1][i];
            end
        end

        always_comb begin
            logic [RW:0] t;
            t = '0;
            for (int i = 0; i < 3; i++) begin
                n_r[i] = p_r[i];
                n_q[i] = p_q[i];
                for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                    if (k * STEPS_PER_STAGE + j < QN) begin
                        // first step takes the integer bit without a shift
                        t = (k * STEPS_PER_STAGE + j == 0) ? n_r[i] : (n_r[i] << 1);
                        if (t >= {1'b0, p_s}) begin
                            n_r[i] = t - {1'b0, p_s};
                            n_q[i] = {n_q[i][QN-2:0], 1'b1};
                        end else begin
                            n_r[i] = t;
                            n_q[i] = {n_q[i][QN-2:0], 1'b0};
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ld[k]) begin
                r_s[k] <= p_s;
                for (int i = 0; i < 3; i++) begin
                    r_r[k][i] <= n_r[i];
                    r_q[k][i] <= n_q[i];
                end
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_out
        assign o_q[i] = r_q[NSTG-1][i];
    end

endmodule

FILE: src/real_spherical_harmonic_eval_top.sv
// Channel   Handshake                     Word
// input     i_in_valid / o_in_ready       i_dir_x, i_dir_y, i_dir_z
// output    o_out_valid / i_out_ready     o_sh_value, o_status
// config    i_cfg_wr (no wait)            i_cfg_addr, i_cfg_wdata
//
// One word per cycle sustained while i_out_ready is high. The square root
// and the three-lane divider set the depth, two iterations per stage.
// Reset clears every valid bit and the configuration registers (degree 0, order 0).
// A stalled output holds; empty stages behind it keep filling, and a word is
// taken whenever stage 0 is empty or moving on.
module real_spherical_harmonic_eval_top #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr,
    input  logic [0:0]                          i_cfg_addr,
    input  logic [2:0]                          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COORD_BITS-1:0]        i_dir_x,
    input  logic signed [COORD_BITS-1:0]        i_dir_y,
    input  logic signed [COORD_BITS-1:0]        i_dir_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rshe_pkg::OUT_W-1:0]   o_sh_value,
    output logic [1:0]                          o_status
);
    import rshe_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int N2W  = 2 * CB;
    localparam int SW   = (N2W > 62) ? N2W : 62;
    localparam int RW   = SW / 2;
    localparam int SQS  = (RW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int QN   = F + 2;
    localparam int DVS  = (QN + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int MW   = F + 6;
    localparam int EW   = 5;

    localparam int S_IN  = 0;
    localparam int S_SQ  = 1;
    localparam int S_N2  = 2;
    localparam int S_E   = 3;
    localparam int S_SH  = 4;
    localparam int S_RT0 = 5;
    localparam int S_DV0 = S_RT0 + SQS;
    localparam int S_U   = S_DV0 + DVS;
    localparam int S_M1  = S_U + 1;
    localparam int S_M2  = S_M1 + 1;
    localparam int S_M3  = S_M2 + 1;
    localparam int S_M4  = S_M3 + 1;
    localparam int S_OUT = S_M4 + 1;
    localparam int NS    = S_OUT + 1;

    function automatic logic [63:0] coef(input logic [63:0] k9);
        return ((k9 << (F + 1)) + 64'd1000000000) / 64'd2000000000;
    endfunction

    localparam logic signed [MW-1:0] ONE    = MW'(64'd1 << F);
    localparam logic signed [MW-1:0] K_L0   = MW'(coef(64'd282095000));
    localparam logic signed [MW-1:0] K_L1   = MW'(coef(64'd488603000));
    localparam logic signed [MW-1:0] K_L2   = MW'(coef(64'd1092548000));
    localparam logic signed [MW-1:0] K_L2Z  = MW'(coef(64'd946176000));
    localparam logic signed [MW-1:0] K_L2C  = MW'(coef(64'd315392000));
    localparam logic signed [MW-1:0] K_L2D  = MW'(coef(64'd546274000));
    localparam logic signed [MW-1:0] K_L3A  = MW'(coef(64'd590043590));
    localparam logic signed [MW-1:0] K_L3B  = MW'(coef(64'd2890611443));
    localparam logic signed [MW-1:0] K_L3C  = MW'(coef(64'd457045799));
    localparam logic signed [MW-1:0] K_L3D  = MW'(coef(64'd373176333));
    localparam logic signed [MW-1:0] K_L3E  = MW'(coef(64'd1445305721));

    // rounded product, halves away from zero
    function automatic logic signed [MW-1:0] fmul(input logic signed [MW-1:0] a,
                                                  input logic signed [MW-1:0] b);
        logic [MW-1:0]   ma;
        logic [MW-1:0]   mb;
        logic [2*MW-1:0] p;
        logic [2*MW-1:0] r;
        ma = a[MW-1] ? MW'(-a) : MW'(a);
        mb = b[MW-1] ? MW'(-b) : MW'(b);
        p  = (2*MW)'(ma) * (2*MW)'(mb);
        r  = (p + ((2*MW)'(1) << (F - 1))) >> F;
        return (a[MW-1] ^ b[MW-1]) ? -MW'(r) : MW'(r);
    endfunction

    // configuration
    logic [1:0]        r_degree;
    logic signed [2:0] r_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            r_order  <= '0;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_addr)
                CFG_DEGREE: r_degree <= i_cfg_wdata[1:0];
                CFG_ORDER:  r_order  <= i_cfg_wdata;
                default:    r_order  <= r_order;
            endcase
        end
    end

    // stage valids and per-stage load enables
    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;
    logic [NS-1:0] vin;
    logic [NS-1:0] ld;

    assign vin = {r_vld[NS-2:0], i_in_valid};

    always_comb begin
        rdy[NS] = i_out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign ld = rdy[NS-1:0] & vin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= vin[k];
                end
            end
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[S_OUT];

    // front end: magnitudes, squares, norm, normalize
    logic signed [CB-1:0] r_c  [3];
    logic [CB-1:0]        r_m1 [3];
    logic [CB-1:0]        r_m2 [3];
    logic [CB-1:0]        r_m3 [3];
    logic [N2W-1:0]       r_sq [3];
    logic [2:0]           r_s1, r_s2, r_s3;
    logic [N2W-1:0]       r_n2, r_n2e;
    logic [EW-1:0]        r_e;
    logic                 r_z3;
    logic [SW-1:0]        r_rad;
    logic [RW-1:0]        r_a4 [3];
    logic [3:0]           r_f4;
    logic [EW-1:0]        n_e;

    // least e with n2 * 4^e at or above 2^60
    always_comb begin
        n_e = EW'(30);
        for (int k = 30; k >= 0; k--) begin
            if (SW'(r_n2) >= (SW'(1) << (60 - 2 * k))) begin
                n_e = EW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[S_IN]) begin
            r_c[0] <= i_dir_x;
            r_c[1] <= i_dir_y;
            r_c[2] <= i_dir_z;
        end
        if (ld[S_SQ]) begin
            for (int i = 0; i < 3; i++) begin
                r_m1[i] <= r_c[i][CB-1] ? CB'(-r_c[i]) : CB'(r_c[i]);
                r_sq[i] <= (r_c[i][CB-1] ? N2W'(CB'(-r_c[i])) : N2W'(CB'(r_c[i])))
                         * (r_c[i][CB-1] ? N2W'(CB'(-r_c[i])) : N2W'(CB'(r_c[i])));
                r_s1[i] <= r_c[i][CB-1];
            end
        end
        if (ld[S_N2]) begin
            r_m2 <= r_m1;
            r_s2 <= r_s1;
            r_n2 <= r_sq[0] + r_sq[1] + r_sq[2];
        end
        if (ld[S_E]) begin
            r_m3  <= r_m2;
            r_s3  <= r_s2;
            r_n2e <= r_n2;
            r_e   <= n_e;
            r_z3  <= (r_n2 == '0);
        end
        if (ld[S_SH]) begin
            r_rad <= SW'(r_n2e) << {r_e, 1'b0};
            for (int i = 0; i < 3; i++) begin
                r_a4[i] <= RW'(r_m3[i]) << r_e;
            end
            r_f4 <= {r_z3, r_s3};
        end
    end

    // square root with side data alongside
    logic [RW-1:0] root;
    logic [RW-1:0] r_qa [SQS][3];
    logic [3:0]    r_qf [SQS];

    rshe_isqrt #(.SW(SW)) u_isqrt (
        .i_clk  (i_clk),
        .i_ld   (ld[S_RT0 +: SQS]),
        .i_rad  (r_rad),
        .o_root (root)
    );

    for (genvar k = 0; k < SQS; k++) begin : g_qside
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (ld[S_RT0]) begin
                    r_qa[0] <= r_a4;
                    r_qf[0] <= r_f4;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (ld[S_RT0 + k]) begin
                    r_qa[k] <= r_qa[k-1];
                    r_qf[k] <= r_qf[k-1];
                end
            end
        end
    end

    // divide each scaled magnitude by the root
    logic [QN-1:0] quo [3];
    logic [3:0]    r_df [DVS];

    rshe_div #(.RW(RW), .QN(QN)) u_div (
        .i_clk (i_clk),
        .i_ld  (ld[S_DV0 +: DVS]),
        .i_s   (root),
        .i_a   (r_qa[SQS-1]),
        .o_q   (quo)
    );

    for (genvar k = 0; k < DVS; k++) begin : g_dside
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (ld[S_DV0]) begin
                    r_df[0] <= r_qf[SQS-1];
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (ld[S_DV0 + k]) begin
                    r_df[k] <= r_df[k-1];
                end
            end
        end
    end

    // unit components and polynomial
    logic signed [MW-1:0] r_u [3];
    logic                 r_zu;
    logic signed [MW-1:0] r_x, r_y, r_z, r_xx, r_yy, r_zz, r_xy, r_yz, r_xz;
    logic                 r_z1;
    logic signed [MW-1:0] r_p, r_q, r_k, r_d;
    t_status              r_st2;
    logic signed [MW-1:0] r_t, r_k3, r_d3;
    t_status              r_st3;
    logic signed [MW-1:0] r_r;
    t_status              r_st4;
    logic signed [OUT_W-1:0] r_val;
    t_status              r_st;

    logic [QN:0]          um [3];
    logic signed [MW-1:0] n_p, n_q, n_k, n_d, z5;
    logic [2:0]           ord_mag;
    t_status              n_st;
    logic signed [63:0]   rw;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // halve with round-up, then cap at one
            um[i] = ({1'b0, quo[i]} + (QN+1)'(1)) >> 1;
            if (um[i] > ((QN+1)'(1) << F)) begin
                um[i] = (QN+1)'(1) << F;
            end
        end
    end

    always_comb begin
        z5      = MW'(5 * r_zz);
        ord_mag = r_order[2] ? 3'(-r_order) : r_order;
        n_p     = ONE;
        n_q     = ONE;
        n_k     = K_L0;
        n_d     = '0;
        unique case (r_degree)
            2'd0: begin
                n_k = K_L0;
            end
            2'd1: begin
                n_k = K_L1;
                n_p = r_order[2] ? r_y : ((r_order == 3'd0) ? r_z : r_x);
            end
            2'd2: begin
                n_k = K_L2;
                unique case (r_order)
                    3'b110:  n_p = r_xy;
                    3'b111:  n_p = r_yz;
                    3'b000: begin
                        n_p = r_zz;
                        n_k = K_L2Z;
                        n_d = K_L2C;
                    end
                    3'b001:  n_p = r_xz;
                    default: begin
                        n_p = r_xx - r_yy;
                        n_k = K_L2D;
                    end
                endcase
            end
            default: begin
                unique case (r_order)
                    3'b101: begin
                        n_k = K_L3A; n_p = r_y;  n_q = MW'(3 * r_xx) - r_yy;
                    end
                    3'b110: begin
                        n_k = K_L3B; n_p = r_xy; n_q = r_z;
                    end
                    3'b111: begin
                        n_k = K_L3C; n_p = r_y;  n_q = z5 - ONE;
                    end
                    3'b000: begin
                        n_k = K_L3D; n_p = r_z;  n_q = z5 - MW'(3 * ONE);
                    end
                    3'b001: begin
                        n_k = K_L3C; n_p = r_x;  n_q = z5 - ONE;
                    end
                    3'b010: begin
                        n_k = K_L3E; n_p = r_xx - r_yy; n_q = r_z;
                    end
                    default: begin
                        n_k = K_L3A; n_p = r_x;  n_q = r_xx - MW'(3 * r_yy);
                    end
                endcase
            end
        endcase

        priority if (ord_mag > {1'b0, r_degree}) begin
            n_st = ST_BAD;
        end else if (r_degree != 2'd0 && r_z1) begin
            n_st = ST_ZERO;
        end else begin
            n_st = ST_OK;
        end
    end

    assign rw = 64'(r_r);

    always_ff @(posedge i_clk) begin
        if (ld[S_U]) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= r_df[DVS-1][i] ? -MW'(um[i]) : MW'(um[i]);
            end
            r_zu <= r_df[DVS-1][3];
        end
        if (ld[S_M1]) begin
            r_x  <= r_u[0];
            r_y  <= r_u[1];
            r_z  <= r_u[2];
            r_xx <= fmul(r_u[0], r_u[0]);
            r_yy <= fmul(r_u[1], r_u[1]);
            r_zz <= fmul(r_u[2], r_u[2]);
            r_xy <= fmul(r_u[0], r_u[1]);
            r_yz <= fmul(r_u[1], r_u[2]);
            r_xz <= fmul(r_u[0], r_u[2]);
            r_z1 <= r_zu;
        end
        if (ld[S_M2]) begin
            r_p   <= n_p;
            r_q   <= n_q;
            r_k   <= n_k;
            r_d   <= n_d;
            r_st2 <= n_st;
        end
        if (ld[S_M3]) begin
            r_t   <= fmul(r_p, r_q);
            r_k3  <= r_k;
            r_d3  <= r_d;
            r_st3 <= r_st2;
        end
        if (ld[S_M4]) begin
            r_r   <= fmul(r_k3, r_t) - r_d3;
            r_st4 <= r_st3;
        end
        if (ld[S_OUT]) begin
            r_st <= r_st4;
            priority if (r_st4 != ST_OK) begin
                r_val <= '0;
            end else if (rw > 64'sd131071) begin
                r_val <= OUT_W'(131071);
            end else if (rw < -64'sd131072) begin
                r_val <= OUT_W'(-131072);
            end else begin
                r_val <= OUT_W'(rw);
            end
        end
    end

    assign o_sh_value = r_val;
    assign o_status   = r_st;

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_BAD |-> o_sh_value == '0)
        else $error("unsupported pair gave a nonzero value");

    a_zero_needs_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_ZERO |-> r_degree != 2'd0)
        else $error("zero-length status at degree 0");

    a_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_ready |-> o_in_ready == !(&r_vld))
        else $error("input ready does not track free pipeline slots");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
